// File: hw/rtl/slxff_pkg.sv
package slxff_pkg;

  localparam int unsigned MaxPayload    = 60;
  localparam int unsigned WindowDepth   = 64;
  localparam int unsigned FrameOverhead = 4;
  localparam int unsigned PtrW          = $clog2(WindowDepth);
  localparam int unsigned FillW         = $clog2(WindowDepth + 1);

  localparam logic [7:0] ResetSyncFirst  = 8'h27;
  localparam logic [7:0] ResetSyncSecond = 8'hA5;

  typedef logic [7:0]       byte_t;
  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [FillW-1:0] fill_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgSyncFirst  = 1'b0,
    CfgSyncSecond = 1'b1
  } cfg_idx_e;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic dvalid;
  } scan_ctl_t;

  // scan unit result
  typedef struct packed {
    logic  found;
    ptr_t  ptr;
    byte_t cnt;
  } scan_res_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(WindowDepth - 1)) begin
      r = '0;
    end else begin
      r = ptr_t'(p + ptr_t'(1));
    end
    return r;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = ptr_t'(WindowDepth - 1);
    end else begin
      r = ptr_t'(p - ptr_t'(1));
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/slxff_window_mem.sv
module slxff_window_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  slxff_pkg::ptr_t  waddr_i,
  input  slxff_pkg::byte_t wdata_i,
  input  logic            re_i,
  input  slxff_pkg::ptr_t  raddr_i,
  output slxff_pkg::byte_t rdata_o
);

  slxff_pkg::byte_t mem_q [slxff_pkg::WindowDepth];
  slxff_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/slxff_scan_unit.sv
module slxff_scan_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slxff_pkg::scan_ctl_t ctl_i,
  input  slxff_pkg::byte_t     data_i,
  input  slxff_pkg::ptr_t      ptr_i,
  input  slxff_pkg::byte_t     sync_first_i,
  input  slxff_pkg::byte_t     sync_second_i,
  output slxff_pkg::scan_res_t res_o
);

  // b1/b2: the two bytes after the current one, x: xor of everything past b2
  slxff_pkg::byte_t b1_q, b1_d, b2_q, b2_d, x_q, x_d;
  slxff_pkg::fill_t dist_q, dist_d;
  logic            found_q, found_d;
  slxff_pkg::ptr_t  mptr_q, mptr_d;
  slxff_pkg::byte_t mcnt_q, mcnt_d;
  logic            hit;

  always_comb begin
    hit = (dist_d >= slxff_pkg::fill_t'(slxff_pkg::FrameOverhead)) &&
          (data_i == sync_first_i) && (b1_q == sync_second_i) &&
          (b2_q <= slxff_pkg::byte_t'(slxff_pkg::MaxPayload)) &&
          ((9'(b2_q) + 9'(slxff_pkg::FrameOverhead)) == 9'(dist_d)) &&
          (x_q == '0);
  end

  always_comb begin
    dist_d  = slxff_pkg::fill_t'(dist_q + slxff_pkg::fill_t'(1));
    b1_d    = b1_q;
    b2_d    = b2_q;
    x_d     = x_q;
    found_d = found_q;
    mptr_d  = mptr_q;
    mcnt_d  = mcnt_q;
    if (ctl_i.clear) begin
      b1_d    = '0;
      b2_d    = '0;
      x_d     = '0;
      found_d = 1'b0;
    end else if (ctl_i.dvalid) begin
      // walking toward older bytes, so a later hit is an earlier start
      if (hit) begin
        found_d = 1'b1;
        mptr_d  = ptr_i;
        mcnt_d  = b2_q;
      end
      x_d  = x_q ^ b2_q;
      b2_d = b1_q;
      b1_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        dist_q <= '0;
      end else if (ctl_i.dvalid) begin
        dist_q <= dist_d;
      end
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    x_q    <= x_d;
    mptr_q <= mptr_d;
    mcnt_q <= mcnt_d;
  end

  assign res_o.found = found_q;
  assign res_o.ptr   = mptr_q;
  assign res_o.cnt   = mcnt_q;

endmodule

// File: hw/rtl/sync_length_xor_frame_finder_core.sv
// sync word / length / xor checksum frame finder
//
// input channel (in_valid_i/in_ready_o, in_byte_i) takes one received byte per
// item into a 64-entry circular window. after each byte the window is walked
// from the newest byte back to the oldest, one memory read per cycle, through
// a shared compare/xor unit; the oldest start that forms a whole frame
// (sync, sync, count, payload, xor check) wins.
// on a match the output channel (out_valid_o/out_ready_i) delivers the count
// item (is_count_o high), then the payload bytes in order, last_o on the final
// item, and the window is emptied. a full window overwrites its oldest byte.
// the single read port of the window memory serves both the walk and the
// payload output, so in_ready_o is high only between items.
// the count item is loaded into the output register when the walk ends;
// each payload item is read from the window, then loaded into the register.
// a stalled receiver holds the output register and the sequencer waits;
// a new byte is taken once the last item of a frame is loaded.
// reset empties the window and loads sync bytes 0x27 and 0xa5; configuration
// writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
module sync_length_xor_frame_finder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_count_o,
  output logic       last_o
);

  typedef enum logic [4:0] {
    StIdle     = 5'b00001,
    StScan     = 5'b00010,
    StEmitCnt  = 5'b00100,
    StEmitRd   = 5'b01000,
    StEmitWait = 5'b10000
  } state_e;

  state_e state_q, state_d;

  slxff_pkg::byte_t sync_first_q, sync_second_q;

  // window bookkeeping
  slxff_pkg::ptr_t  tail_q, tail_d;
  slxff_pkg::fill_t fill_q, fill_d, fill_new;
  slxff_pkg::ptr_t  ptr_q, ptr_d;
  slxff_pkg::fill_t left_q, left_d;
  slxff_pkg::byte_t rem_q, rem_d;
  logic            rd_vld_q, rd_vld_d;
  slxff_pkg::ptr_t  rd_addr_q;

  // memory port
  logic            mem_we, mem_re;
  slxff_pkg::byte_t mem_rdata;

  // output register
  logic            out_valid_q, out_valid_d;
  slxff_pkg::byte_t out_byte_q, out_byte_d;
  logic            is_count_q, is_count_d;
  logic            last_q, last_d;
  logic            out_free;

  slxff_pkg::scan_ctl_t scan_ctl;
  slxff_pkg::scan_res_t scan_res;

  logic in_acc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // full window keeps its fill, the write lands on the oldest byte
  assign fill_new = (fill_q == slxff_pkg::fill_t'(slxff_pkg::WindowDepth)) ?
                    fill_q : slxff_pkg::fill_t'(fill_q + slxff_pkg::fill_t'(1));

  always_comb begin
    state_d     = state_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    rem_d       = rem_q;
    rd_vld_d    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    is_count_d  = is_count_q;
    last_d      = last_q;
    scan_ctl.clear  = 1'b0;
    scan_ctl.dvalid = rd_vld_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          mem_we         = 1'b1;
          tail_d         = slxff_pkg::ptr_inc(tail_q);
          fill_d         = fill_new;
          ptr_d          = tail_q;
          left_d         = fill_new;
          scan_ctl.clear = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        if (left_q != '0) begin
          // read newest to oldest, data reaches the scan unit in the next cycle
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = slxff_pkg::ptr_dec(ptr_q);
          left_d   = slxff_pkg::fill_t'(left_q - slxff_pkg::fill_t'(1));
        end else if (!rd_vld_q) begin
          state_d = scan_res.found ? StEmitCnt : StIdle;
        end
      end
      StEmitCnt: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = scan_res.cnt;
          is_count_d  = 1'b1;
          last_d      = (scan_res.cnt == '0);
          fill_d      = '0;
          rem_d       = scan_res.cnt;
          // first payload byte sits three places after the first sync byte
          ptr_d       = slxff_pkg::ptr_inc(slxff_pkg::ptr_inc(
                          slxff_pkg::ptr_inc(scan_res.ptr)));
          state_d     = (scan_res.cnt == '0) ? StIdle : StEmitRd;
        end
      end
      StEmitRd: begin
        mem_re  = 1'b1;
        ptr_d   = slxff_pkg::ptr_inc(ptr_q);
        state_d = StEmitWait;
      end
      StEmitWait: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = mem_rdata;
          is_count_d  = 1'b0;
          last_d      = (rem_q == slxff_pkg::byte_t'(1));
          rem_d       = slxff_pkg::byte_t'(rem_q - slxff_pkg::byte_t'(1));
          state_d     = (rem_q == slxff_pkg::byte_t'(1)) ? StIdle : StEmitRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      sync_first_q  <= slxff_pkg::ResetSyncFirst;
      sync_second_q <= slxff_pkg::ResetSyncSecond;
      tail_q        <= '0;
      fill_q        <= '0;
      left_q        <= '0;
      rem_q         <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      rem_q       <= rem_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slxff_pkg::CfgSyncFirst:  sync_first_q  <= cfg_data_i;
          slxff_pkg::CfgSyncSecond: sync_second_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    rd_addr_q  <= ptr_q;
    out_byte_q <= out_byte_d;
    is_count_q <= is_count_d;
    last_q     <= last_d;
  end

  slxff_window_mem u_window_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (in_byte_i),
    .re_i    (mem_re),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  slxff_scan_unit u_scan_unit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .data_i        (mem_rdata),
    .ptr_i         (rd_addr_q),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .res_o         (scan_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_count_o  = is_count_q;
  assign last_o      = last_q;

endmodule
